// File: hdl/mktd_pkg.sv
package mktd_pkg;

   localparam int MAX_ELEMENTS = 8;
   localparam int ELEM_CNT_W   = $clog2(MAX_ELEMENTS + 1);
   localparam int ROM_DEPTH    = 36;

   localparam logic [15:0] DOT_THRESHOLD_RESET = 16'd200;
   localparam logic [15:0] LETTER_PAUSE_RESET  = 16'd600;
   localparam logic [15:0] WORD_PAUSE_RESET    = 16'd1400;

   localparam logic [1:0] CSR_DOT_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_LETTER_PAUSE  = 2'd1;
   localparam logic [1:0] CSR_WORD_PAUSE    = 2'd2;

   localparam logic [7:0] CHAR_UNKNOWN = 8'h3F;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_EOM     = 8'h00;

   // end-of-message prosign .-.-. (bit i is element i, 1 = dash)
   localparam logic [ELEM_CNT_W-1:0]   EOM_LEN  = ELEM_CNT_W'(5);
   localparam logic [MAX_ELEMENTS-1:0] EOM_BITS = MAX_ELEMENTS'(10);

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_message;
      logic       last;
   } rsp_item_type;

   localparam logic [2:0] ROM_LEN [ROM_DEPTH] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
      3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
      3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
   };

   localparam logic [4:0] ROM_BITS [ROM_DEPTH] = '{
      5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14,
      5'd5, 5'd2, 5'd3, 5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1,
      5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
      5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
   };

   localparam logic [7:0] ROM_CHAR [ROM_DEPTH] = '{
      8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
      8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
      8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
   };

   function automatic logic [7:0] decode_code(
      input logic [ELEM_CNT_W-1:0]   len,
      input logic [MAX_ELEMENTS-1:0] bits
   );
      logic [7:0] ch;
      ch = CHAR_UNKNOWN;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         if (len == ELEM_CNT_W'(ROM_LEN[i]) && bits == MAX_ELEMENTS'(ROM_BITS[i])) begin
            ch = ROM_CHAR[i];
         end
      end
      return ch;
   endfunction

endpackage

// File: hdl/morse_key_timing_decoder_core.sv
// Morse key timing decoder. One key sample (0 pressed, 1 released) is taken
// per tick on req_; a sample can be accepted every cycle, and the result items
// it causes are queued and offered on rsp_ in order. A press shorter than
// dot_threshold ticks is a dot, else a dash. After release, a gap of
// letter_pause ticks decodes the pending code into a letter or digit ('?' if
// unknown or too long), and a gap of word_pause ticks adds a space. The
// prosign .-.-. yields one item with character 0 and end_of_message set, and
// no space follows it. A sample causes zero, one or two result items;
// rsp_last marks the final one. Results wait in a four-item queue; req_ready
// is low while three or more items wait, so a sample that causes two items
// always finds room, and a stalled rsp_ side stops input once the queue
// holds three. The csr_ port (index 0 dot_threshold, 1 letter_pause,
// 2 word_pause) is always ready; other indexes are ignored.
module morse_key_timing_decoder_core
   import mktd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_key_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_character,
   output logic        rsp_end_of_message,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int QDEPTH = 4;

   logic [15:0] dot_threshold_ff, dot_threshold_in;
   logic [15:0] letter_pause_ff, letter_pause_in;
   logic [15:0] word_pause_ff, word_pause_in;

   logic                    previous_level_ff, previous_level_in;
   logic [15:0]             press_count_ff, press_count_in;
   logic [15:0]             gap_count_ff, gap_count_in;
   logic                    gap_active_ff, gap_active_in;
   logic [MAX_ELEMENTS-1:0] element_bits_ff, element_bits_in;
   logic [ELEM_CNT_W-1:0]   element_count_ff, element_count_in;
   logic                    code_overflow_ff, code_overflow_in;

   rsp_item_type q_ff [QDEPTH];
   rsp_item_type q_in [QDEPTH];
   logic [2:0]   cnt_ff, cnt_in;

   logic         req_accept;
   logic         pop;
   logic         dash;
   logic [15:0]  gap_next;
   logic [15:0]  lg_eff;
   logic [15:0]  wg_eff;
   logic         at_word;
   logic         letter_fire;
   logic         is_eom;
   logic [7:0]   letter_char;
   logic [1:0]   n_results;
   rsp_item_type r0;
   rsp_item_type r1;
   logic [2:0]   base;

   assign csr_ready  = 1'b1;
   assign req_ready  = (cnt_ff <= 3'd2);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = (cnt_ff != 3'd0);
   assign pop        = rsp_valid && rsp_ready;

   assign rsp_character      = q_ff[0].character;
   assign rsp_end_of_message = q_ff[0].end_of_message;
   assign rsp_last           = q_ff[0].last;

   always_comb begin
      dot_threshold_in = dot_threshold_ff;
      letter_pause_in  = letter_pause_ff;
      word_pause_in    = word_pause_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DOT_THRESHOLD: dot_threshold_in = csr_wdata;
            CSR_LETTER_PAUSE:  letter_pause_in  = csr_wdata;
            CSR_WORD_PAUSE:    word_pause_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   assign dash        = (press_count_ff >= dot_threshold_ff);
   assign gap_next    = (gap_count_ff == 16'hFFFF) ? gap_count_ff : gap_count_ff + 16'd1;
   assign lg_eff      = (letter_pause_ff == 16'd0) ? 16'd1 : letter_pause_ff;
   assign wg_eff      = (word_pause_ff == 16'd0) ? 16'd1 : word_pause_ff;
   assign is_eom      = !code_overflow_ff && element_count_ff == EOM_LEN
                        && element_bits_ff == EOM_BITS;
   assign letter_char = code_overflow_ff ? CHAR_UNKNOWN
                        : decode_code(element_count_ff, element_bits_ff);

   always_comb begin
      previous_level_in = previous_level_ff;
      press_count_in    = press_count_ff;
      gap_count_in      = gap_count_ff;
      gap_active_in     = gap_active_ff;
      element_bits_in   = element_bits_ff;
      element_count_in  = element_count_ff;
      code_overflow_in  = code_overflow_ff;
      at_word           = 1'b0;
      letter_fire       = 1'b0;
      n_results         = 2'd0;
      r0                = '{character: CHAR_SPACE, end_of_message: 1'b0, last: 1'b1};
      r1                = '{character: CHAR_SPACE, end_of_message: 1'b0, last: 1'b1};

      if (req_accept) begin
         previous_level_in = req_key_level;
         if (!req_key_level) begin
            if (previous_level_ff) begin
               press_count_in = 16'd1;
               gap_active_in  = 1'b0;
            end else if (press_count_ff != 16'hFFFF) begin
               press_count_in = press_count_ff + 16'd1;
            end
         end else if (!previous_level_ff) begin
            if (element_count_ff < ELEM_CNT_W'(MAX_ELEMENTS)) begin
               element_bits_in = element_bits_ff
                                 | (MAX_ELEMENTS'(dash) << element_count_ff);
               element_count_in = element_count_ff + ELEM_CNT_W'(1);
            end else begin
               code_overflow_in = 1'b1;
            end
            gap_active_in = 1'b1;
            gap_count_in  = 16'd0;
         end else if (gap_active_ff) begin
            gap_count_in = gap_next;
            at_word      = (gap_next == wg_eff);
            letter_fire  = (gap_next == lg_eff || at_word)
                           && (element_count_ff != '0 || code_overflow_ff);
            if (letter_fire) begin
               element_bits_in  = '0;
               element_count_in = '0;
               code_overflow_in = 1'b0;
               if (is_eom) begin
                  gap_active_in = 1'b0;
                  at_word       = 1'b0;
               end
            end
            if (at_word) begin
               gap_active_in = 1'b0;
            end
            n_results = {1'b0, letter_fire} + {1'b0, at_word};
            if (letter_fire) begin
               r0.character      = is_eom ? CHAR_EOM : letter_char;
               r0.end_of_message = is_eom;
               r0.last           = !at_word;
            end
         end
      end
   end

   assign base = cnt_ff - {2'b00, pop};

   always_comb begin
      for (int i = 0; i < QDEPTH; i++) begin
         if (pop && i < QDEPTH - 1) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (n_results != 2'd0 && base == 3'(i)) begin
            q_in[i] = r0;
         end
         if (n_results == 2'd2 && base + 3'd1 == 3'(i)) begin
            q_in[i] = r1;
         end
      end
      cnt_in = base + {1'b0, n_results};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_threshold_ff  <= DOT_THRESHOLD_RESET;
         letter_pause_ff   <= LETTER_PAUSE_RESET;
         word_pause_ff     <= WORD_PAUSE_RESET;
         previous_level_ff <= 1'b1;
         press_count_ff    <= '0;
         gap_count_ff      <= '0;
         gap_active_ff     <= 1'b0;
         element_bits_ff   <= '0;
         element_count_ff  <= '0;
         code_overflow_ff  <= 1'b0;
         cnt_ff            <= '0;
      end else begin
         dot_threshold_ff  <= dot_threshold_in;
         letter_pause_ff   <= letter_pause_in;
         word_pause_ff     <= word_pause_in;
         previous_level_ff <= previous_level_in;
         press_count_ff    <= press_count_in;
         gap_count_ff      <= gap_count_in;
         gap_active_ff     <= gap_active_in;
         element_bits_ff   <= element_bits_in;
         element_count_ff  <= element_count_in;
         code_overflow_ff  <= code_overflow_in;
         cnt_ff            <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(QDEPTH))
      else $error("result queue count out of range");

   a_elem_bound: assert property (@(posedge clock) disable iff (reset)
      element_count_ff <= ELEM_CNT_W'(MAX_ELEMENTS))
      else $error("element count beyond limit");

   a_eom_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_message |-> rsp_character == CHAR_EOM && rsp_last)
      else $error("end of message item malformed");

   a_press_stops_gap: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_key_level |=> !gap_active_ff)
      else $error("gap timing active during press");

endmodule
